// File: sv/amdfs_pkg.sv
// ----------------------------------------------------------------------------
// amdfs_pkg
// Shared types, field widths and codes for the adjacency matrix DFS block.
// ----------------------------------------------------------------------------
package amdfs_pkg;

    localparam int DEFAULT_MAX_VERTICES = 64;

    localparam int OPCODE_W = 2;
    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 7;
    localparam int ROW_W    = 64;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] RD_A     = 2'd0;
    localparam logic [1:0] RD_B     = 2'd1;
    localparam logic [1:0] RD_TOP   = 2'd2;
    localparam logic [1:0] RD_STACK = 2'd3;

    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic       load_item;
        logic       clear_graph;
        logic       row_rd;
        logic [1:0] row_rd_sel;
        logic       row_wr_a;
        logic       row_wr_b;
        logic       search_init;
        logic       push;
        logic       pop;
        logic       stack_rd;
        logic       top_from_stack;
        logic       emit_last;
        logic       emit_bad;
    } cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                edge_ok;
        logic                start_ok;
        logic                cand_any;
        logic                depth_one;
        logic                out_free;
    } status_t;

endpackage

// File: sv/amdfs_ctrl.sv
// ----------------------------------------------------------------------------
// amdfs_ctrl
// Sequencer for edge updates, graph clear and the depth-first walk.
// ----------------------------------------------------------------------------
module amdfs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  amdfs_pkg::status_t status,
    output amdfs_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_ADD_RD_A = 4'd2;
    localparam logic [3:0] ST_ADD_WR_A = 4'd3;
    localparam logic [3:0] ST_ADD_RD_B = 4'd4;
    localparam logic [3:0] ST_ADD_WR_B = 4'd5;
    localparam logic [3:0] ST_INIT     = 4'd6;
    localparam logic [3:0] ST_RD       = 4'd7;
    localparam logic [3:0] ST_EVAL     = 4'd8;
    localparam logic [3:0] ST_POP_RD   = 4'd9;
    localparam logic [3:0] ST_POP_TOP  = 4'd10;
    localparam logic [3:0] ST_END      = 4'd11;
    localparam logic [3:0] ST_BAD      = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = aresetn && (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.op)
                    amdfs_pkg::OP_ADD: begin
                        state_next = status.edge_ok ? ST_ADD_RD_A : ST_IDLE;
                    end
                    amdfs_pkg::OP_CLEAR: begin
                        cmd.clear_graph = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    amdfs_pkg::OP_SEARCH: begin
                        state_next = status.start_ok ? ST_INIT : ST_BAD;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ADD_RD_A: begin
                cmd.row_rd     = 1'b1;
                cmd.row_rd_sel = amdfs_pkg::RD_A;
                state_next     = ST_ADD_WR_A;
            end
            ST_ADD_WR_A: begin
                cmd.row_wr_a = 1'b1;
                state_next   = ST_ADD_RD_B;
            end
            ST_ADD_RD_B: begin
                cmd.row_rd     = 1'b1;
                cmd.row_rd_sel = amdfs_pkg::RD_B;
                state_next     = ST_ADD_WR_B;
            end
            ST_ADD_WR_B: begin
                cmd.row_wr_b = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_INIT: begin
                cmd.search_init = 1'b1;
                state_next      = ST_RD;
            end
            ST_RD: begin
                cmd.row_rd     = 1'b1;
                cmd.row_rd_sel = amdfs_pkg::RD_TOP;
                state_next     = ST_EVAL;
            end
            ST_EVAL: begin
                if (status.cand_any) begin
                    if (status.out_free) begin
                        cmd.push   = 1'b1;
                        state_next = ST_RD;
                    end
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = status.depth_one ? ST_END : ST_POP_RD;
                end
            end
            ST_POP_RD: begin
                cmd.stack_rd = 1'b1;
                state_next   = ST_POP_TOP;
            end
            ST_POP_TOP: begin
                cmd.top_from_stack = 1'b1;
                cmd.row_rd         = 1'b1;
                cmd.row_rd_sel     = amdfs_pkg::RD_STACK;
                state_next         = ST_EVAL;
            end
            ST_END: begin
                if (status.out_free) begin
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_BAD: begin
                if (status.out_free) begin
                    cmd.emit_bad = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/amdfs_datapath.sv
// ----------------------------------------------------------------------------
// amdfs_datapath
// Adjacency row memory, vertex stack, visited map, neighbor search and the
// result register.
// ----------------------------------------------------------------------------
module amdfs_datapath #(
    parameter int MAX_VERTICES = amdfs_pkg::DEFAULT_MAX_VERTICES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  amdfs_pkg::cmd_t                    cmd,
    output amdfs_pkg::status_t                 status,
    input  logic [amdfs_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                               cfg_valid,
    input  logic [amdfs_pkg::COUNT_W-1:0]      cfg_data,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [amdfs_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = amdfs_pkg::COUNT_W;
    localparam int XW = amdfs_pkg::VERTEX_W;
    localparam int OW = amdfs_pkg::OPCODE_W;
    localparam logic [CW-1:0] MAX_V = CW'(MAX_VERTICES);

    amdfs_pkg::row_t row_mem   [MAX_VERTICES];
    logic [XW-1:0]   stack_mem [MAX_VERTICES];

    logic [MAX_VERTICES-1:0] row_valid_reg;
    amdfs_pkg::row_t         row_q_reg;
    logic                    row_vq_reg;
    logic [XW-1:0]           stack_q_reg;
    logic [VW:0]             depth_reg;
    logic [XW-1:0]           top_reg;
    amdfs_pkg::row_t         visited_reg;
    logic [XW-1:0]           pend_reg;
    logic [OW-1:0]           op_reg;
    logic [XW-1:0]           a_reg;
    logic [XW-1:0]           b_reg;
    logic [CW-1:0]           vcount_reg;
    logic                    out_valid_reg;
    logic [XW-1:0]           out_vertex_reg;
    logic                    out_last_reg;
    logic                    out_bad_reg;

    logic [CW-1:0]   n_eff;
    amdfs_pkg::row_t mask;
    amdfs_pkg::row_t row_eff;
    amdfs_pkg::row_t cand;
    logic [XW-1:0]   nxt;
    logic [VW-1:0]   rd_addr;
    logic [VW:0]     depth_m1;
    logic            out_free;

    assign n_eff    = (vcount_reg > MAX_V) ? MAX_V : vcount_reg;
    assign row_eff  = row_vq_reg ? row_q_reg : '0;
    assign cand     = row_eff & mask & ~visited_reg;
    assign depth_m1 = depth_reg - (VW + 1)'(1);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        for (int i = 0; i < amdfs_pkg::ROW_W; i++) begin
            mask[i] = (CW'(i) < n_eff);
        end
    end

    always_comb begin
        nxt = '0;
        for (int i = amdfs_pkg::ROW_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                nxt = XW'(i);
            end
        end
    end

    always_comb begin
        case (cmd.row_rd_sel)
            amdfs_pkg::RD_A:     rd_addr = a_reg[VW-1:0];
            amdfs_pkg::RD_B:     rd_addr = b_reg[VW-1:0];
            amdfs_pkg::RD_TOP:   rd_addr = top_reg[VW-1:0];
            amdfs_pkg::RD_STACK: rd_addr = stack_q_reg[VW-1:0];
            default:             rd_addr = top_reg[VW-1:0];
        endcase
    end

    assign status.op        = op_reg;
    assign status.edge_ok   = ({1'b0, a_reg} < MAX_V) && ({1'b0, b_reg} < MAX_V);
    assign status.start_ok  = ({1'b0, a_reg} < n_eff);
    assign status.cand_any  = |cand;
    assign status.depth_one = (depth_reg == (VW + 1)'(1));
    assign status.out_free  = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg <= s_tdata[OW-1:0];
            a_reg  <= s_tdata[OW+XW-1:OW];
            b_reg  <= s_tdata[OW+2*XW-1:OW+XW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= amdfs_pkg::VCOUNT_RESET;
        end else if (cfg_valid) begin
            vcount_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_rd) begin
            row_q_reg  <= row_mem[rd_addr];
            row_vq_reg <= row_valid_reg[rd_addr];
        end
        if (cmd.row_wr_a) begin
            row_mem[a_reg[VW-1:0]] <= row_eff | (amdfs_pkg::row_t'(1) << b_reg);
        end else if (cmd.row_wr_b) begin
            row_mem[b_reg[VW-1:0]] <= row_eff | (amdfs_pkg::row_t'(1) << a_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (cmd.clear_graph) begin
            row_valid_reg <= '0;
        end else if (cmd.row_wr_a) begin
            row_valid_reg[a_reg[VW-1:0]] <= 1'b1;
        end else if (cmd.row_wr_b) begin
            row_valid_reg[b_reg[VW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search_init) begin
            stack_mem[0] <= a_reg;
        end else if (cmd.push) begin
            stack_mem[depth_reg[VW-1:0]] <= nxt;
        end
        if (cmd.stack_rd) begin
            stack_q_reg <= stack_mem[depth_m1[VW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            visited_reg <= '0;
        end else if (cmd.search_init) begin
            depth_reg   <= (VW + 1)'(1);
            visited_reg <= amdfs_pkg::row_t'(1) << a_reg;
        end else if (cmd.push) begin
            depth_reg   <= depth_reg + (VW + 1)'(1);
            visited_reg <= visited_reg | (amdfs_pkg::row_t'(1) << nxt);
        end else if (cmd.pop) begin
            depth_reg   <= depth_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search_init) begin
            top_reg  <= a_reg;
            pend_reg <= a_reg;
        end else if (cmd.push) begin
            top_reg  <= nxt;
            pend_reg <= nxt;
        end else if (cmd.top_from_stack) begin
            top_reg  <= stack_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push || cmd.emit_last || cmd.emit_bad) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            out_vertex_reg <= pend_reg;
            out_last_reg   <= 1'b0;
            out_bad_reg    <= 1'b0;
        end else if (cmd.emit_last) begin
            out_vertex_reg <= pend_reg;
            out_last_reg   <= 1'b1;
            out_bad_reg    <= 1'b0;
        end else if (cmd.emit_bad) begin
            out_vertex_reg <= '0;
            out_last_reg   <= 1'b1;
            out_bad_reg    <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(amdfs_pkg::M_TDATA_W - XW){1'b0}}, out_vertex_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

endmodule

// File: sv/adjacency_matrix_dfs_order.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_order
// Undirected graph store with depth-first visit order streaming.
// ----------------------------------------------------------------------------
// Each request is an add-edge, a clear or a search. An add-edge makes two
// read-modify-write passes on the single-port row memory, and a clear needs
// no pass over the rows, since per-row valid bits drop the whole matrix at
// once. A search has a setup step, the walk and the closing result: a push
// costs one row read and one evaluation, a pop adds a stack read before the
// next row read, and a push waits while the result side stalls. Results
// come out in visit order, start vertex first, with tlast on the final one;
// a start at or above the vertex count gives a single result with tuser set.
// No new request is taken until the last result of a search sits in the
// output register.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_order #(
    parameter int MAX_VERTICES = amdfs_pkg::DEFAULT_MAX_VERTICES
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: opcode [1:0], vertex_a [7:2], vertex_b [13:8], zero fill
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [amdfs_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: visited_vertex [5:0], zero fill
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [amdfs_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    // m_tuser: bad_start [0]
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [amdfs_pkg::COUNT_W-1:0]   cfg_data
);

    amdfs_pkg::cmd_t    cmd;
    amdfs_pkg::status_t status;

    assign cfg_ready = aresetn;

    amdfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    amdfs_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
